// ===== rtl/twbb_pkg.sv =====
// Shared types and constants for the time-weighted balance bar block.
// Used by the channel interfaces, the shared arithmetic unit and the top level.
package twbb_pkg;

  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned DELTA_W       = 48;
  localparam int unsigned BAL_W         = 64;
  localparam int unsigned PERIOD_W      = 16;
  localparam int unsigned CFG_W         = 48;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned STEP_W        = 7;

  localparam logic [BAL_W-1:0] BAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [BAL_W-1:0] BAL_MIN = 64'h8000_0000_0000_0000;

  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAR_PERIOD = 1'b0,
    CFG_FIRST_TIME = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    UOP_DIV = 1'b0,
    UOP_MUL = 1'b1
  } uop_t;

  typedef struct packed {
    logic                start;
    uop_t                op;
    logic [STEP_W-1:0]   steps;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   mag;
    logic                neg;
    logic [PERIOD_W-1:0] divisor;
  } twbb_ctl_t;

  typedef struct packed {
    logic                busy;
    logic [WORD_W-1:0]   word;
    logic [PERIOD_W-1:0] rem;
    logic [WORD_W-1:0]   product;
  } twbb_stat_t;

endpackage

// ===== rtl/twbb_if.sv =====
// Valid/ready channel interfaces for the balance changes and the bar results.
// Depends on twbb_pkg for the field widths.
interface twbb_in_if;
  import twbb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [TIME_W-1:0]         time_stamp;
  logic signed [DELTA_W-1:0] delta;
  modport source (output valid, kind, time_stamp, delta, input ready);
  modport sink (input valid, kind, time_stamp, delta, output ready);
endinterface

interface twbb_out_if;
  import twbb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       bar_start;
  logic signed [BAL_W-1:0] min_balance;
  logic signed [BAL_W-1:0] max_balance;
  logic signed [BAL_W-1:0] mean_balance;
  logic [TIME_W-1:0]       bar_count;
  logic                    last_of_run;
  modport source (output valid, bar_start, min_balance, max_balance, mean_balance,
                  bar_count, last_of_run, input ready);
  modport sink (input valid, bar_start, min_balance, max_balance, mean_balance,
                bar_count, last_of_run, output ready);
endinterface

// ===== rtl/twbb_unit.sv =====
// Shared iterative unit: restoring division by the bar period and saturating
// shift-add multiplication, one bit per cycle. Depends on twbb_pkg.
module twbb_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  twbb_pkg::twbb_ctl_t  ctl,
  output twbb_pkg::twbb_stat_t stat
);
  import twbb_pkg::*;

  logic [STEP_W-1:0]   count;
  uop_t                op;
  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   acc;
  logic [WORD_W-1:0]   mag;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] divisor;
  logic                neg;
  logic                over;

  logic [PERIOD_W:0]   rem_shift;
  logic                rem_ge;
  logic [PERIOD_W:0]   rem_sub;
  logic [WORD_W+1:0]   mul_sum;
  logic [WORD_W-1:0]   mul_lim;
  logic                mul_over;

  // Division step: bring down the next dividend bit, subtract when it fits.
  assign rem_shift = {rem, word[WORD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  // Multiply step, most significant bit first; the magnitude limit is one
  // larger for a negative product.
  assign mul_sum  = {1'b0, acc, 1'b0} + {2'b00, (word[WORD_W-1] ? mag : '0)};
  assign mul_lim  = BAL_MAX + WORD_W'(neg);
  assign mul_over = over || (mul_sum > {2'b00, mul_lim});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.start) begin
      count   <= ctl.steps;
      op      <= ctl.op;
      word    <= ctl.word;
      mag     <= ctl.mag;
      neg     <= ctl.neg;
      divisor <= ctl.divisor;
      acc     <= '0;
      rem     <= '0;
      over    <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      case (op)
        UOP_DIV: begin
          rem  <= rem_ge ? rem_sub[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
          word <= {word[WORD_W-2:0], rem_ge};
        end
        UOP_MUL: begin
          if (mul_over) begin
            over <= 1'b1;
          end else begin
            acc <= mul_sum[WORD_W-1:0];
          end
          word <= {word[WORD_W-2:0], 1'b0};
        end
        default: begin
          word <= word;
        end
      endcase
    end
  end

  always_comb begin
    stat.busy = count != '0;
    stat.word = word;
    stat.rem  = rem;
    if (over) begin
      stat.product = neg ? BAL_MIN : BAL_MAX;
    end else begin
      stat.product = neg ? (~acc + 1'b1) : acc;
    end
  end

endmodule

// ===== rtl/time_weighted_balance_bars_top.sv =====
// Top level of the time-weighted balance bar block: sequencer, state and output
// register around the shared unit. Depends on twbb_pkg, twbb_if and twbb_unit.
//
// Usage. Balance changes arrive on in_ch (kind, time_stamp, delta) as valid/ready
// transactions; closed bars leave on out_ch. Each bar result carries its start
// time, the lowest and highest balance, the time-weighted mean and a repeat
// count; a run of empty bars after a closed bar comes as a second result with
// count of one or more. last_of_run marks the final result of one input transaction.
// A finish transaction (kind 1) flushes the complete bars up to its time and
// clears the state. bar_period and first_time are written on the cfg port.
//
// Timing. One transaction is handled at a time and in_ch.ready is high only
// while the sequencer is idle. A change inside the open bar needs one
// multiplication on the shared unit; one that closes a bar needs a division of
// the span by the period, a multiplication for the tail, the 64-bit average
// division, a second result when a run of empty bars follows, and a
// multiplication for the new bar. A finish that closes bars skips that last
// multiplication, and one that closes none does not use the unit. The first
// transaction after reset or finish adds a division to set up the first bar.
// The shared unit produces one quotient or product bit per cycle.
//
// Reset clears the sequencer, the output valid flag and the started flag and
// sets bar_period to 1 and first_time to 0. A stalled receiver holds the
// result in the output register; the sequencer then waits before loading the
// next result, while the last result of a transaction never blocks in_ch.
module time_weighted_balance_bars_top #(
  parameter int unsigned TIME_BITS = twbb_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  twbb_pkg::cfg_idx_t                cfg_addr,
  input  logic [twbb_pkg::CFG_W-1:0]        cfg_data,
  twbb_in_if.sink                           in_ch,
  twbb_out_if.source                        out_ch
);
  import twbb_pkg::*;

  localparam int unsigned ALIGN = WORD_W - TIME_BITS;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_START  = 15'h0002,
    S_CLAMP  = 15'h0004,
    S_DECIDE = 15'h0008,
    S_QDIV   = 15'h0010,
    S_CMUL   = 15'h0020,
    S_CADD   = 15'h0040,
    S_ADIV   = 15'h0080,
    S_OUT0   = 15'h0100,
    S_OUT1   = 15'h0200,
    S_ADV    = 15'h0400,
    S_NMUL   = 15'h0800,
    S_PMUL   = 15'h1000,
    S_PADD   = 15'h2000,
    S_FIN    = 15'h4000
  } state_t;

  state_t state;
  logic   issued;

  // Configuration registers.
  logic [PERIOD_W-1:0] bar_period;
  logic [TIME_W-1:0]   first_time;

  // Bar state.
  logic                    started;
  logic [TIME_BITS-1:0]    bar_begin;
  logic [TIME_BITS-1:0]    prior_time;
  logic signed [BAL_W-1:0] running_balance;
  logic signed [BAL_W-1:0] low_mark;
  logic signed [BAL_W-1:0] high_mark;
  logic signed [BAL_W-1:0] weighted_sum;

  // Current transaction and intermediate results.
  logic                      kind;
  logic [TIME_BITS-1:0]      t_cur;
  logic signed [DELTA_W-1:0] delta;
  logic [TIME_BITS-1:0]      quot;
  logic [PERIOD_W-1:0]       rem;
  logic signed [BAL_W-1:0]   prod;

  // Output register.
  logic                    out_valid;
  logic [TIME_W-1:0]       out_start;
  logic signed [BAL_W-1:0] out_min;
  logic signed [BAL_W-1:0] out_max;
  logic signed [BAL_W-1:0] out_avg;
  logic [TIME_W-1:0]       out_count;
  logic                    out_last;

  twbb_ctl_t  uctl;
  twbb_stat_t ustat;

  logic [PERIOD_W-1:0]     period;
  logic [TIME_BITS-1:0]    first_t;
  logic [TIME_BITS-1:0]    first_floor;
  logic [TIME_BITS-1:0]    span;
  logic [TIME_BITS-1:0]    gap;
  logic [TIME_BITS:0]      bar_end;
  logic [TIME_BITS-1:0]    tail;
  logic signed [BAL_W-1:0] next_balance;
  logic [WORD_W-1:0]       rb_mag;
  logic [WORD_W-1:0]       ws_mag;
  logic [BAL_W-1:0]        avg_val;
  logic                    unit_done;
  logic                    out_free;
  logic                    out_load;

  function automatic logic signed [BAL_W-1:0] sat_add(input logic signed [BAL_W-1:0] a,
                                                      input logic signed [BAL_W-1:0] b);
    logic [BAL_W:0] s;
    s = {a[BAL_W-1], a} + {b[BAL_W-1], b};
    if (s[BAL_W] != s[BAL_W-1]) begin
      sat_add = s[BAL_W] ? BAL_MIN : BAL_MAX;
    end else begin
      sat_add = s[BAL_W-1:0];
    end
  endfunction

  // A zero period behaves as a period of one.
  assign period      = (bar_period == '0) ? PERIOD_W'(1) : bar_period;
  assign first_t     = TIME_BITS'(first_time);
  assign first_floor = first_t - TIME_BITS'(ustat.rem);
  assign span        = t_cur - bar_begin;
  assign gap         = t_cur - prior_time;
  assign bar_end     = {1'b0, bar_begin} + (TIME_BITS + 1)'(period);
  // The part of the open bar after the last change; none if a shortened
  // period put the bar end before it.
  assign tail = (bar_end > {1'b0, prior_time}) ?
                TIME_BITS'(bar_end - {1'b0, prior_time}) : '0;

  assign next_balance = sat_add(running_balance, BAL_W'(delta));
  assign rb_mag  = running_balance[BAL_W-1] ? (~running_balance + 1'b1) : running_balance;
  assign ws_mag  = weighted_sum[BAL_W-1] ? (~weighted_sum + 1'b1) : weighted_sum;
  // The quotient of the magnitude takes the sign back: truncation toward zero.
  assign avg_val = weighted_sum[BAL_W-1] ? (~ustat.word + 1'b1) : ustat.word;

  assign unit_done = issued && !ustat.busy;
  assign out_free  = !out_valid || out_ch.ready;
  // A result is loaded whenever the sequencer offers one and the register frees up.
  assign out_load  = out_free && ((state == S_OUT0) || (state == S_OUT1));

  // Operand selection for the shared unit; time operands sit in the top bits
  // so that the unit runs only TIME_BITS steps on them.
  always_comb begin
    uctl.start   = 1'b0;
    uctl.op      = UOP_DIV;
    uctl.steps   = STEP_W'(TIME_BITS);
    uctl.word    = '0;
    uctl.mag     = rb_mag;
    uctl.neg     = running_balance[BAL_W-1];
    uctl.divisor = period;
    case (state)
      S_START: begin
        uctl.start = !issued && !started;
        uctl.word  = WORD_W'(first_t) << ALIGN;
      end
      S_QDIV: begin
        uctl.start = !issued;
        uctl.word  = WORD_W'(span) << ALIGN;
      end
      S_CMUL: begin
        uctl.start = !issued;
        uctl.op    = UOP_MUL;
        uctl.word  = WORD_W'(tail) << ALIGN;
      end
      S_ADIV: begin
        uctl.start = !issued;
        uctl.steps = STEP_W'(WORD_W);
        uctl.word  = ws_mag;
      end
      S_NMUL: begin
        uctl.start = !issued;
        uctl.op    = UOP_MUL;
        uctl.word  = WORD_W'(span) << ALIGN;
      end
      S_PMUL: begin
        uctl.start = !issued;
        uctl.op    = UOP_MUL;
        uctl.word  = WORD_W'(gap) << ALIGN;
      end
      default: begin
        uctl.start = 1'b0;
      end
    endcase
  end

  twbb_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .ctl  (uctl),
    .stat (ustat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued     <= 1'b0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
      bar_period <= PERIOD_W'(1);
      first_time <= '0;
    end else begin
      if (cfg_en) begin
        case (cfg_addr)
          CFG_BAR_PERIOD: bar_period <= cfg_data[PERIOD_W-1:0];
          CFG_FIRST_TIME: first_time <= cfg_data[TIME_W-1:0];
          default:        bar_period <= bar_period;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (uctl.start) begin
        issued <= 1'b1;
      end else if (unit_done) begin
        issued <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind  <= in_ch.kind;
            t_cur <= TIME_BITS'(in_ch.time_stamp);
            delta <= in_ch.delta;
            state <= S_START;
          end
        end
        // The first bar begins at first_time rounded down to the period.
        S_START: begin
          if (started) begin
            state <= S_CLAMP;
          end else if (unit_done) begin
            bar_begin       <= first_floor;
            prior_time      <= first_floor;
            running_balance <= '0;
            low_mark        <= '0;
            high_mark       <= '0;
            weighted_sum    <= '0;
            started         <= 1'b1;
            state           <= S_CLAMP;
          end
        end
        // A time earlier than the last change counts as that change's time.
        S_CLAMP: begin
          if (t_cur < prior_time) begin
            t_cur <= prior_time;
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (span >= TIME_BITS'(period)) begin
            state <= S_QDIV;
          end else if (kind == KIND_FINISH) begin
            state <= S_FIN;
          end else begin
            state <= S_PMUL;
          end
        end
        S_QDIV: begin
          if (unit_done) begin
            quot  <= ustat.word[TIME_BITS-1:0];
            rem   <= ustat.rem;
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          if (unit_done) begin
            prod  <= ustat.product;
            state <= S_CADD;
          end
        end
        S_CADD: begin
          weighted_sum <= sat_add(weighted_sum, prod);
          state        <= S_ADIV;
        end
        S_ADIV: begin
          if (unit_done) begin
            state <= S_OUT0;
          end
        end
        S_OUT0: begin
          if (out_free) begin
            out_start <= TIME_W'(bar_begin);
            out_min   <= low_mark;
            out_max   <= high_mark;
            out_avg   <= avg_val;
            out_count <= TIME_W'(1);
            out_last  <= quot <= TIME_BITS'(1);
            state     <= (quot > TIME_BITS'(1)) ? S_OUT1 : S_ADV;
          end
        end
        // Empty bars hold the running balance throughout.
        S_OUT1: begin
          if (out_free) begin
            out_start <= TIME_W'(bar_end);
            out_min   <= running_balance;
            out_max   <= running_balance;
            out_avg   <= running_balance;
            out_count <= TIME_W'(quot - 1'b1);
            out_last  <= 1'b1;
            state     <= S_ADV;
          end
        end
        S_ADV: begin
          bar_begin <= t_cur - TIME_BITS'(rem);
          state     <= (kind == KIND_FINISH) ? S_FIN : S_NMUL;
        end
        // New bar: the old balance held from its start up to this change.
        S_NMUL: begin
          if (unit_done) begin
            weighted_sum <= ustat.product;
            low_mark     <= (next_balance < running_balance) ? next_balance : running_balance;
            high_mark    <= (next_balance > running_balance) ? next_balance : running_balance;
            state        <= S_FIN;
          end
        end
        S_PMUL: begin
          if (unit_done) begin
            prod  <= ustat.product;
            state <= S_PADD;
          end
        end
        S_PADD: begin
          weighted_sum <= sat_add(weighted_sum, prod);
          if (next_balance < low_mark) begin
            low_mark <= next_balance;
          end
          if (next_balance > high_mark) begin
            high_mark <= next_balance;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (kind == KIND_FINISH) begin
            bar_begin       <= '0;
            prior_time      <= '0;
            running_balance <= '0;
            low_mark        <= '0;
            high_mark       <= '0;
            weighted_sum    <= '0;
            started         <= 1'b0;
          end else begin
            running_balance <= next_balance;
            prior_time      <= t_cur;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = state == S_IDLE;
  assign out_ch.valid        = out_valid;
  assign out_ch.bar_start    = out_start;
  assign out_ch.min_balance  = out_min;
  assign out_ch.max_balance  = out_max;
  assign out_ch.mean_balance = out_avg;
  assign out_ch.bar_count    = out_count;
  assign out_ch.last_of_run  = out_last;

endmodule

// ===== rtl/twbb_check.sv =====
// Port-level checks for the time-weighted balance bar block, attached to the
// top level by the bind at the end. Depends on twbb_pkg.
module twbb_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [twbb_pkg::TIME_W-1:0]           bar_start,
  input logic signed [twbb_pkg::BAL_W-1:0]     min_balance,
  input logic signed [twbb_pkg::BAL_W-1:0]     max_balance,
  input logic signed [twbb_pkg::BAL_W-1:0]     mean_balance,
  input logic [twbb_pkg::TIME_W-1:0]           bar_count,
  input logic                                  last_of_run
);
  import twbb_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bar_start) && $stable(min_balance)
      && $stable(max_balance) && $stable(mean_balance) && $stable(bar_count)
      && $stable(last_of_run))
    else $error("stalled result changed");

  // A run of empty bars reports the held balance in all three values.
  a_run_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && bar_count != TIME_W'(1) |->
      min_balance == max_balance && max_balance == mean_balance && last_of_run)
    else $error("empty bar run with differing values");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_balance <= max_balance)
    else $error("bar minimum above maximum");

endmodule

bind time_weighted_balance_bars_top twbb_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .bar_start    (out_ch.bar_start),
  .min_balance  (out_ch.min_balance),
  .max_balance  (out_ch.max_balance),
  .mean_balance (out_ch.mean_balance),
  .bar_count    (out_ch.bar_count),
  .last_of_run  (out_ch.last_of_run)
);

// ===== tb/tb_time_weighted_balance_bars_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for time_weighted_balance_bars_top: a clocked driver and monitor
// check every bar result against a bit-exact predictor of the bar aggregation.
// Depends on twbb_pkg, the twbb_in_if/twbb_out_if interfaces and the block's top level.
module tb_time_weighted_balance_bars_top;
  import twbb_pkg::*;

  // No transaction on either channel for this many cycles ends the run. The slowest legal
  // quiet stretch is the long receiver hold or the settling pause, each well under it.
  localparam int unsigned STALL_LIMIT   = 20000;
  // Cycles allowed after the last expected result before a register write or the end.
  // This covers the slowest transaction, including the first-bar set-up.
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned ITEM_TARGET   = 1700;
  localparam logic [63:0] TIME_MASK     = (64'd1 << TIME_BITS_DEF) - 64'd1;
  localparam logic [47:0] DELTA_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] DELTA_MIN     = 48'h8000_0000_0000;

  typedef struct {
    logic              kind;
    logic [TIME_W-1:0] stamp;
    logic [DELTA_W-1:0] delta;
  } change_t;

  typedef struct {
    logic [TIME_W-1:0]       start;
    logic signed [BAL_W-1:0] lo;
    logic signed [BAL_W-1:0] hi;
    logic signed [BAL_W-1:0] avg;
    logic [TIME_W-1:0]       count;
    logic                    last;
  } bar_t;

  logic clk;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic              cfg_en   = 1'b0;
  cfg_idx_t          cfg_addr = CFG_BAR_PERIOD;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic               drv_valid = 1'b0;
  logic               drv_kind  = KIND_CHANGE;
  logic [TIME_W-1:0]  drv_stamp = '0;
  logic [DELTA_W-1:0] drv_delta = '0;
  logic               rcv_ready = 1'b0;

  twbb_in_if  in_ch ();
  twbb_out_if out_ch ();

  assign in_ch.valid      = drv_valid;
  assign in_ch.kind       = drv_kind;
  assign in_ch.time_stamp = drv_stamp;
  assign in_ch.delta      = drv_delta;
  assign out_ch.ready     = rcv_ready;

  time_weighted_balance_bars_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow copies of the two registers, updated as they are written.
  logic [63:0] cfg_period = 64'd1;
  logic [63:0] cfg_first  = 64'd0;

  // Predicted state of the open bar.
  logic [63:0]             bar_open_at  = '0;
  logic [63:0]             last_stamp   = '0;
  logic signed [BAL_W-1:0] balance      = '0;
  logic signed [BAL_W-1:0] bar_low      = '0;
  logic signed [BAL_W-1:0] bar_high     = '0;
  logic signed [BAL_W-1:0] bar_integral = '0;
  bit                      bar_live     = 1'b0;

  bar_t    bars_due[$];
  change_t pending_changes[$];

  int errors  = 0;
  int queued  = 0;
  bit calm    = 1'b0;
  bit hold_req = 1'b0;

  // The integral, the sums and the balance all clip at the signed 64-bit range.
  function automatic logic signed [63:0] clip_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? BAL_MIN : BAL_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clip_product(input logic signed [63:0] a,
                                                      input logic [63:0] b);
    logic signed [128:0] pr;
    pr = $signed({{65{a[63]}}, a}) * $signed({65'd0, b});
    if (pr[128:63] == '0 || pr[128:63] == '1) return pr[63:0];
    return pr[128] ? BAL_MIN : BAL_MAX;
  endfunction

  // A period of zero behaves as a period of one.
  function automatic logic [63:0] period_eff();
    return (cfg_period == 64'd0) ? 64'd1 : cfg_period;
  endfunction

  function automatic void clear_bar_state();
    bar_open_at  = '0;
    last_stamp   = '0;
    balance      = '0;
    bar_low      = '0;
    bar_high     = '0;
    bar_integral = '0;
    bar_live     = 1'b0;
  endfunction

  // Closes the open bar and folds the empty bars up to t into one run. If the open bar
  // ended before the last change (the period shrank mid-bar), its tail counts as zero.
  function automatic void close_bars(input logic [63:0] t);
    logic [63:0] p, bar_stop, dt, q, reps;
    bar_t r;
    p = period_eff();
    bar_stop = bar_open_at + p;
    dt = (bar_stop > last_stamp) ? bar_stop - last_stamp : 64'd0;
    bar_integral = clip_sum(bar_integral, clip_product(balance, dt));
    r.start = bar_open_at[47:0];
    r.lo    = bar_low;
    r.hi    = bar_high;
    r.avg   = bar_integral / $signed(p);
    r.count = 48'd1;
    r.last  = 1'b0;
    q = (t - bar_open_at) / p;
    if (q > 64'd1) begin
      bars_due.insert(bars_due.size(), r);
      reps    = q - 64'd1;
      r.start = bar_stop[47:0];
      r.lo    = balance;
      r.hi    = balance;
      r.avg   = balance;
      r.count = reps[47:0];
    end
    r.last = 1'b1;
    bars_due.insert(bars_due.size(), r);
    bar_open_at = bar_open_at + q * p;
  endfunction

  // Works out the bars that one accepted transaction closes and advances the state.
  function automatic void predict_bars(input logic kind, input logic [47:0] stamp,
                                       input logic [47:0] delta);
    logic [63:0] p, t;
    logic signed [63:0] d, nxt;
    p = period_eff();
    if (!bar_live) begin
      bar_open_at  = ((cfg_first & TIME_MASK) / p) * p;
      last_stamp   = bar_open_at;
      balance      = '0;
      bar_low      = '0;
      bar_high     = '0;
      bar_integral = '0;
      bar_live     = 1'b1;
    end
    t = {16'd0, stamp} & TIME_MASK;
    d = {{16{delta[47]}}, delta};
    // Time running backwards is held at the last change.
    if (t < last_stamp) t = last_stamp;
    if (kind == KIND_FINISH) begin
      if (t - bar_open_at >= p) close_bars(t);
      clear_bar_state();
    end else begin
      nxt = clip_sum(balance, d);
      if (t - bar_open_at >= p) begin
        close_bars(t);
        bar_low      = (nxt < balance) ? nxt : balance;
        bar_high     = (nxt > balance) ? nxt : balance;
        bar_integral = clip_product(balance, t - bar_open_at);
      end else begin
        bar_integral = clip_sum(bar_integral, clip_product(balance, t - last_stamp));
        if (nxt < bar_low) bar_low = nxt;
        if (nxt > bar_high) bar_high = nxt;
      end
      balance    = nxt;
      last_stamp = t;
    end
  endfunction

  // Driver: presents queued changes, holding each until its transaction completes.
  // Idle bursts come in chains, so gaps land at any point of the block's work; in the
  // calm part of the run there are none.
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (drv_valid && in_ch.ready) predict_bars(drv_kind, drv_stamp, drv_delta);
      if (!drv_valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (!calm && pending_changes.size() > 0 && $urandom_range(0, 2) == 0) begin
          send_gap = $urandom_range(0, 11);
          drv_valid <= 1'b0;
        end else if (pending_changes.size() > 0) begin
          drv_kind  <= pending_changes[0].kind;
          drv_stamp <= pending_changes[0].stamp;
          drv_delta <= pending_changes[0].delta;
          void'(pending_changes.pop_front());
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compares each result with the oldest predicted bar. Ready drops in random
  // bursts, and once for a long hold so that the output register fills and the block
  // backs up onto its input while the driver keeps offering.
  int   rcv_gap   = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bar_t want_bar;

  always @(posedge clk) begin
    if (rst) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) begin
        if (bars_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual bar_start %h count %h",
                   $time, out_ch.bar_start, out_ch.bar_count);
          errors++;
        end else begin
          want_bar = bars_due.pop_front();
          check_field("bar_start", 64'(want_bar.start), 64'(out_ch.bar_start));
          check_field("min_balance", want_bar.lo, out_ch.min_balance);
          check_field("max_balance", want_bar.hi, out_ch.max_balance);
          check_field("mean_balance", want_bar.avg, out_ch.mean_balance);
          check_field("bar_count", 64'(want_bar.count), 64'(out_ch.bar_count));
          check_field("last_of_run", 64'(want_bar.last), 64'(out_ch.last_of_run));
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        rcv_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rcv_gap = $urandom_range(0, 11);
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, bars_due.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus generation.
  logic [63:0] gen_time = '0;
  bit          fresh    = 1'b1;

  task automatic offer(input logic kind, input logic [63:0] stamp, input logic [47:0] delta);
    change_t c;
    c.kind  = kind;
    c.stamp = stamp[47:0];
    c.delta = delta;
    pending_changes.insert(pending_changes.size(), c);
    queued++;
  endtask

  // Waits at the falling edge, where driver and predictor have settled, until every
  // queued change has been taken and every predicted bar has arrived, then lets the
  // block finish any transaction that closes no bar.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_changes.size() != 0 || drv_valid || bars_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
    @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == CFG_BAR_PERIOD) cfg_period = {48'd0, value[15:0]};
    else cfg_first = {16'd0, value};
  endtask

  function automatic logic [47:0] pick_delta();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      s = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      return {{16{s[31]}}, s};
    end
    if (r < 72) return '0;
    if (r < 88) return 48'({$urandom, $urandom});
    if (r < 94) return DELTA_MAX;
    return DELTA_MIN;
  endfunction

  // Advances the generated time: mostly within the open bar or a few bars on, now and
  // then a long run of empty bars, a step backwards or a wild stamp.
  function automatic logic [63:0] next_stamp();
    logic [63:0] p, back;
    int r;
    p = period_eff();
    r = $urandom_range(0, 99);
    if (fresh) begin
      gen_time = cfg_first + 64'($urandom_range(0, 2 * int'(p[16:0])));
      fresh = 1'b0;
    end else if (r < 55) begin
      gen_time = gen_time + 64'($urandom_range(0, int'(p[16:0]) - 1));
    end else if (r < 85) begin
      gen_time = gen_time + p * 64'($urandom_range(1, 3)) +
                 64'($urandom_range(0, int'(p[16:0]) - 1));
    end else if (r < 93) begin
      gen_time = gen_time + p * 64'($urandom_range(4, 2000));
    end else if (r < 97) begin
      back = 64'($urandom_range(0, 3 * int'(p[16:0])));
      gen_time = (gen_time > back) ? gen_time - back : 64'd0;
    end else begin
      gen_time = {16'd0, 48'({$urandom, $urandom})};
    end
    gen_time = gen_time & TIME_MASK;
    return gen_time;
  endfunction

  // One stretch of well-formed activity, with a little noise: an early finish here
  // and there, and usually a closing finish.
  task automatic run_phase(input int count, input bit closing);
    logic [63:0] t;
    for (int i = 0; i < count; i++) begin
      t = next_stamp();
      if ($urandom_range(0, 24) == 0) begin
        offer(KIND_FINISH, t, pick_delta());
        fresh = 1'b1;
      end else begin
        offer(KIND_CHANGE, t, pick_delta());
      end
    end
    if (closing) begin
      offer(KIND_FINISH, next_stamp(), pick_delta());
      fresh = 1'b1;
    end
  endtask

  initial begin
    logic [47:0] period_val;
    logic [47:0] first_val;
    int r;
    int phase;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset values first: a period of one, so the step to time 5 closes bars.
    offer(KIND_CHANGE, 64'd0, 48'h0000_0001_0000);
    offer(KIND_CHANGE, 64'd5, 48'hFFFF_FFFD_0000);
    offer(KIND_CHANGE, 64'd5, DELTA_MAX);
    offer(KIND_FINISH, 64'd5, DELTA_MIN);
    wait_drained();

    // A period of zero behaves as one; the delta of a finish is ignored.
    write_reg(CFG_BAR_PERIOD, 48'hABCD_0000_0000);
    write_reg(CFG_FIRST_TIME, 48'd0);
    offer(KIND_CHANGE, 64'd3, 48'd5);
    offer(KIND_CHANGE, 64'd7, DELTA_MAX);
    offer(KIND_FINISH, 64'd9, 48'h1234_5678_9ABC);
    wait_drained();

    // Largest period and latest start: time running backwards, extreme deltas, and a
    // finish before any bar is complete.
    write_reg(CFG_BAR_PERIOD, 48'd65535);
    write_reg(CFG_FIRST_TIME, 48'hFFFF_FFFF_FFFF);
    offer(KIND_CHANGE, 64'hFFFF_FFFF_FFFF, DELTA_MAX);
    offer(KIND_CHANGE, 64'd0, DELTA_MIN);
    offer(KIND_CHANGE, 64'hFFFF_FFFF_FFFF, DELTA_MAX);
    offer(KIND_FINISH, 64'hFFFF_FFFF_FFFF, DELTA_MAX);
    wait_drained();

    // A first bar that starts below first_time, long empty runs and a backward step.
    write_reg(CFG_BAR_PERIOD, 48'd7);
    write_reg(CFG_FIRST_TIME, 48'd100);
    offer(KIND_CHANGE, 64'd100, 48'd1);
    offer(KIND_CHANGE, 64'd103, DELTA_MAX);
    offer(KIND_CHANGE, 64'd200, DELTA_MIN);
    offer(KIND_CHANGE, 64'd150, 48'd5);
    offer(KIND_FINISH, 64'd1000, 48'd0);
    wait_drained();

    // A saturating integral and a jump to the end of time.
    write_reg(CFG_BAR_PERIOD, 48'd65535);
    write_reg(CFG_FIRST_TIME, 48'd0);
    offer(KIND_CHANGE, 64'd10, DELTA_MAX);
    offer(KIND_CHANGE, 64'hFFFF_FFFF_FFFF, DELTA_MIN);
    offer(KIND_FINISH, 64'hFFFF_FFFF_FFFF, 48'd0);
    wait_drained();

    // The period shrinks mid-bar, so the open bar ends before the last change.
    write_reg(CFG_BAR_PERIOD, 48'd100);
    offer(KIND_CHANGE, 64'd50, 48'h0000_0003_0000);
    offer(KIND_CHANGE, 64'd90, 48'hFFFF_FFFF_8000);
    wait_drained();
    write_reg(CFG_BAR_PERIOD, 48'd10);
    offer(KIND_CHANGE, 64'd95, 48'h0000_0001_0000);
    offer(KIND_FINISH, 64'd500, 48'd0);
    fresh = 1'b1;

    // Random part: phases of well-formed activity under varying settings. Each phase
    // boundary also makes the sender pause until every predicted bar has arrived.
    phase = 0;
    while (queued < ITEM_TARGET) begin
      wait_drained();
      r = $urandom_range(0, 99);
      if (r < 60) period_val = 48'($urandom_range(1, 16));
      else if (r < 85) period_val = 48'($urandom_range(17, 1000));
      else if (r < 93) period_val = {32'($urandom), 16'($urandom)};
      else if (r < 96) period_val = 48'd65535;
      else period_val = 48'd0;
      write_reg(CFG_BAR_PERIOD, period_val);
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) first_val = 48'($urandom_range(0, 5000));
        else if (r < 80) first_val = 48'({$urandom, $urandom});
        else if (r < 90) first_val = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100000));
        else first_val = 48'd0;
        write_reg(CFG_FIRST_TIME, first_val);
      end
      // Early on, hold the receiver off for a long stretch while the driver keeps going.
      if (phase == 3) hold_req <= 1'b1;
      if (queued >= ITEM_TARGET * 85 / 100) calm <= 1'b1;
      run_phase($urandom_range(8, 40), $urandom_range(0, 3) != 0);
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/twbb_pkg.sv
rtl/twbb_if.sv
rtl/twbb_unit.sv
rtl/time_weighted_balance_bars_top.sv
rtl/twbb_check.sv
tb/tb_time_weighted_balance_bars_top.sv
